// ===== rtl/kfrr_pkg.sv =====
// shared types, constants and helpers for the k-line frame receiver and responder
`default_nettype none

package kfrr_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgTesterAddr = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgEcuAddr    = 4'd1;

  localparam logic [7:0] TesterAddrRst = 8'hC1;
  localparam logic [7:0] EcuAddrRst    = 8'hF0;

  // frame format
  localparam logic [3:0] FmtNibble     = 4'h8;
  localparam logic [4:0] FrameOverhead = 5'd3;
  localparam logic [4:0] MinRespEnd    = 5'd5;
  localparam logic [4:0] PosTarget     = 5'd1;
  localparam logic [4:0] PosSource     = 5'd2;
  localparam logic [4:0] PosData0      = 5'd3;
  localparam logic [4:0] PosData1      = 5'd4;
  localparam logic [7:0] ServiceId     = 8'h21;
  localparam logic [7:0] LocalId       = 8'h01;

  // response frame
  localparam int unsigned RespLen  = 7;
  localparam int unsigned RespIdxW = $clog2(RespLen);
  localparam logic [RespIdxW-1:0] RespLast = RespIdxW'(RespLen - 1);
  localparam logic [7:0] RespFmt    = 8'h83;
  localparam logic [7:0] RespTarget = 8'hF0;
  localparam logic [7:0] RespSource = 8'hC1;
  localparam logic [7:0] RespSid    = 8'h61;
  localparam logic [7:0] RespLid    = 8'h01;
  localparam logic [7:0] RespSumBase =
    8'((RespFmt + RespTarget + RespSource + RespSid + RespLid) % 256);

  // job queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic       respond;
    logic       sw;
    logic [7:0] count;
  } job_t;

  // response byte at a given position; switch byte is 0 when the switch level is high
  function automatic logic [7:0] resp_byte(logic [RespIdxW-1:0] idx, logic sw);
    logic [7:0] b;
    case (idx)
      3'd0:    b = RespFmt;
      3'd1:    b = RespTarget;
      3'd2:    b = RespSource;
      3'd3:    b = RespSid;
      3'd4:    b = RespLid;
      3'd5:    b = {7'd0, ~sw};
      3'd6:    b = RespSumBase + {7'd0, ~sw};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kfrr_front.sv =====
// frame parser: checks each byte and issues one job per accepted byte
`default_nettype none

module kfrr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  wire logic [7:0]     rx_byte_i,
  input  wire logic           switch_level_i,
  input  wire logic [7:0]     tester_addr_i,
  input  wire logic [7:0]     ecu_addr_i,
  output kfrr_pkg::job_t      job_o
);

  logic [4:0] pos_q, pos_d;
  logic [4:0] end_q, end_d;
  logic [7:0] sum_q, sum_d;
  logic       svc_q, svc_d;
  logic       lid_q, lid_d;
  logic [7:0] cnt_q, cnt_d;
  logic       respond;

  always_comb begin
    pos_d   = pos_q;
    end_d   = end_q;
    sum_d   = sum_q;
    svc_d   = svc_q;
    lid_d   = lid_q;
    cnt_d   = cnt_q;
    respond = 1'b0;
    if (pos_q == 5'd0) begin
      if (rx_byte_i[7:4] == kfrr_pkg::FmtNibble) begin
        end_d = 5'(rx_byte_i[5:0]) + kfrr_pkg::FrameOverhead;
        sum_d = rx_byte_i;
        svc_d = 1'b0;
        lid_d = 1'b0;
        pos_d = 5'd1;
      end else begin
        pos_d = 5'd0;
        end_d = 5'd0;
      end
    end else if (pos_q == kfrr_pkg::PosTarget || pos_q == kfrr_pkg::PosSource) begin
      if (rx_byte_i == ((pos_q == kfrr_pkg::PosTarget) ? tester_addr_i : ecu_addr_i)) begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 5'd1;
      end else begin
        pos_d = 5'd0;
        end_d = 5'd0;
      end
    end else if (pos_q < end_q) begin
      if (pos_q == kfrr_pkg::PosData0) begin
        svc_d = (rx_byte_i == kfrr_pkg::ServiceId);
      end else if (pos_q == kfrr_pkg::PosData1) begin
        lid_d = (rx_byte_i == kfrr_pkg::LocalId);
      end
      sum_d = sum_q + rx_byte_i;
      pos_d = pos_q + 5'd1;
    end else begin
      // checksum byte, or an unreachable position past the end
      if (pos_q == end_q && rx_byte_i == sum_q) begin
        cnt_d   = cnt_q + 8'd1;
        respond = (end_q >= kfrr_pkg::MinRespEnd) && svc_q && lid_q;
      end
      pos_d = 5'd0;
      end_d = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
      end_q <= 5'd0;
      sum_q <= 8'd0;
      svc_q <= 1'b0;
      lid_q <= 1'b0;
      cnt_q <= 8'd0;
    end else if (take_i) begin
      pos_q <= pos_d;
      end_q <= end_d;
      sum_q <= sum_d;
      svc_q <= svc_d;
      lid_q <= lid_d;
      cnt_q <= cnt_d;
    end
  end

  assign job_o.respond = respond;
  assign job_o.sw      = switch_level_i;
  assign job_o.count   = cnt_d;

endmodule

`default_nettype wire

// ===== rtl/kfrr_job_queue.sv =====
// small register fifo of jobs between the parser and the result sequencer
`default_nettype none

module kfrr_job_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire kfrr_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output kfrr_pkg::job_t      job_o,
  output logic                empty_o
);

  kfrr_pkg::job_t mem_q [kfrr_pkg::QueueDepth];
  logic [kfrr_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [kfrr_pkg::QueueCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == kfrr_pkg::QueueCntW'(kfrr_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == kfrr_pkg::QueuePtrW'(kfrr_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == kfrr_pkg::QueuePtrW'(kfrr_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kfrr_back.sv =====
// result sequencer: turns each job into one status result or a response frame
`default_nettype none

module kfrr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire kfrr_pkg::job_t job_i,
  input  wire logic           job_empty_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic                has_byte_o,
  output logic [7:0]          tx_byte_o,
  output logic                last_o,
  output logic [7:0]          frame_count_o
);

  logic                          vld_q, vld_d;
  logic                          has_q, has_d;
  logic [7:0]                    byte_q, byte_d;
  logic                          last_q, last_d;
  logic [7:0]                    cnt_q, cnt_d;
  logic [kfrr_pkg::RespIdxW-1:0] idx_q, idx_d;
  logic                          load;
  logic                          job_done;

  assign load     = !vld_q || pop_i;
  assign job_done = !job_i.respond || (idx_q == kfrr_pkg::RespLast);

  always_comb begin
    vld_d     = vld_q;
    has_d     = has_q;
    byte_d    = byte_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    job_pop_o = 1'b0;
    if (load) begin
      vld_d = !job_empty_i;
      if (!job_empty_i) begin
        has_d  = job_i.respond;
        byte_d = job_i.respond ? kfrr_pkg::resp_byte(idx_q, job_i.sw) : 8'h00;
        last_d = job_done;
        cnt_d  = job_i.count;
        if (job_done) begin
          job_pop_o = 1'b1;
          idx_d     = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    has_q  <= has_d;
    byte_q <= byte_d;
    last_q <= last_d;
    cnt_q  <= cnt_d;
  end

  assign empty_o       = !vld_q;
  assign has_byte_o    = has_q;
  assign tx_byte_o     = byte_q;
  assign last_o        = last_q;
  assign frame_count_o = cnt_q;

`ifndef SYNTHESIS
  // mid-response the job must still sit at the queue head
  a_idx_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> !job_empty_i)
    else $error("response in progress without a queued job");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= kfrr_pkg::RespLast)
    else $error("response index out of range");

  // a status result always closes its input byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !has_q |-> last_q && byte_q == 8'h00)
    else $error("status result not final or carries a byte");

  // a held result must not change while waiting
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !pop_i |=> vld_q && $stable(byte_q) && $stable(last_q) && $stable(cnt_q))
    else $error("waiting result changed");
`endif

endmodule

`default_nettype wire

// ===== rtl/kline_frame_receiver_responder.sv =====
// top level of the k-line frame receiver and responder
`default_nettype none

// k-line frame receiver: bytes are pushed in one per cycle while the job
// queue has room, and each one gives one status result, except the checksum
// byte of a valid frame whose data begins 21 01, which gives the seven-byte
// response 83 f0 c1 61 01, switch byte, checksum. a parser at the front
// takes a byte in every cycle while its job queue (four entries) has room;
// a sequencer at the back drains one result per cycle into an output
// register while results are popped. so the input side runs at one byte per
// cycle, and a response gives seven results, during which the front keeps
// accepting until the queue fills. when nothing waits, the first result of
// a byte passes through the job queue and the output register, then can
// be popped. configuration writes are always taken (ready is tied high)
// and must only be made while the block is idle.
module kline_frame_receiver_responder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request input side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic                          switch_level_i,
  // result side
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               has_byte_o,
  output logic [7:0]                         tx_byte_o,
  output logic                               last_o,
  output logic [7:0]                         frame_count_o,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kfrr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i
);

  logic [7:0]     tester_addr_q;
  logic [7:0]     ecu_addr_q;
  logic           take;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  kfrr_pkg::job_t front_job;
  kfrr_pkg::job_t head_job;

  // configuration registers, writes to unknown indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tester_addr_q <= kfrr_pkg::TesterAddrRst;
      ecu_addr_q    <= kfrr_pkg::EcuAddrRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == kfrr_pkg::CfgTesterAddr) begin
        tester_addr_q <= cfg_data_i;
      end
      if (cfg_index_i == kfrr_pkg::CfgEcuAddr) begin
        ecu_addr_q <= cfg_data_i;
      end
    end
  end

  // a request is taken whenever the job queue has room
  assign full = q_full;
  assign take = push && !q_full;

  // front: parse bytes and classify each one as status or response
  kfrr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .rx_byte_i      (rx_byte_i),
    .switch_level_i (switch_level_i),
    .tester_addr_i  (tester_addr_q),
    .ecu_addr_i     (ecu_addr_q),
    .job_o          (front_job)
  );

  // queue decoupling the parser from the result sequencer
  kfrr_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // back: expand each job into results behind the output register
  kfrr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_empty_i   (q_empty),
    .job_pop_o     (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .has_byte_o    (has_byte_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o),
    .frame_count_o (frame_count_o)
  );

endmodule

`default_nettype wire
